// ===== hw/rtl/bft_pkg.sv =====
// ----------------------------------------------------------------------------
// Build-file tokenizer package
// Shared types, token codes and keyword tables for the tokenizer blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package bft_pkg;

  // Scanner phases of the back part.
  typedef enum logic [3:0] {
    PH_LINE,
    PH_MID,
    PH_WORD,
    PH_PIPE,
    PH_SPACES,
    PH_CR,
    PH_COMMENT,
    PH_COMMENT_CR,
    PH_DONE,
    PH_ERROR
  } phase_e;

  // Byte classes produced by the front part.
  typedef enum logic [3:0] {
    CL_IDENT,
    CL_HASH,
    CL_PIPE,
    CL_CR,
    CL_LF,
    CL_EQUALS,
    CL_COLON,
    CL_SPACE,
    CL_BAD,
    CL_EOF
  } cls_e;

  // Token kinds; keywords take the codes 0 to NUM_KW-1 in table order.
  localparam logic [3:0] TK_IDENT   = 4'd6;
  localparam logic [3:0] TK_COLON   = 4'd7;
  localparam logic [3:0] TK_EQUALS  = 4'd8;
  localparam logic [3:0] TK_PIPE    = 4'd9;
  localparam logic [3:0] TK_PIPE2   = 4'd10;
  localparam logic [3:0] TK_NEWLINE = 4'd11;
  localparam logic [3:0] TK_INDENT  = 4'd12;
  localparam logic [3:0] TK_EOF     = 4'd13;
  localparam logic [3:0] TK_BADCHAR = 4'd14;
  localparam logic [3:0] TK_BADCR   = 4'd15;

  localparam int NUM_KW = 6;
  localparam int KW_BYTES = 8;

  // Keyword text with its first character in the lowest byte, so the
  // literals read backwards; unused upper bytes are zero.
  localparam logic [8*KW_BYTES-1:0] KW_TEXT [NUM_KW] = '{
    64'("dliub"),
    64'("tluafed"),
    64'("edulcni"),
    64'("loop"),
    64'("elur"),
    64'("ajninbus")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd5, 4'd7, 4'd7, 4'd4, 4'd4, 4'd8};

  localparam int IQ_DEPTH = 4;
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  // Up to two tokens written into the result queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    token_t     t0;
    token_t     t1;
  } tok_pair_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bft_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front part
// Accepts bytes, classifies each one and holds it in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_front
  import bft_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       end_of_input_i,
  output item_t           item_o,
  output logic            item_valid_o,
  input  wire logic       item_take_i
);

  localparam int PW = $clog2(IQ_DEPTH);
  localparam int CW = $clog2(IQ_DEPTH + 1);

  item_t           mem_q [IQ_DEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [CW-1:0]   count_q, count_d;
  cls_e            cls;
  logic            wr, rd;

  always_comb begin
    if (end_of_input_i) begin
      cls = CL_EOF;
    end else begin
      unique case (byte_value_i) inside
        ["0":"9"], ["a":"z"], ["A":"Z"], "_", ".", "-": cls = CL_IDENT;
        "#":     cls = CL_HASH;
        "|":     cls = CL_PIPE;
        8'h0d:   cls = CL_CR;
        8'h0a:   cls = CL_LF;
        "=":     cls = CL_EQUALS;
        ":":     cls = CL_COLON;
        " ":     cls = CL_SPACE;
        default: cls = CL_BAD;
      endcase
    end
  end

  assign full         = (count_q == CW'(IQ_DEPTH));
  assign wr           = push && !full;
  assign item_valid_o = (count_q != '0);
  assign rd           = item_take_i && item_valid_o;
  assign item_o       = mem_q[rp_q];

  always_comb begin
    count_d = count_q;
    if (wr && !rd) begin
      count_d = count_q + 1'b1;
    end else if (rd && !wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (wr) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= '{cls: cls, data: byte_value_i};
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(IQ_DEPTH))
    else $error("input queue fill count above its depth");

endmodule

`default_nettype wire

// ===== hw/rtl/bft_back.sv =====
// ----------------------------------------------------------------------------
// Tokenizer back part
// Scanner state machine: turns classified bytes into zero to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_back
  import bft_pkg::*;
#(
  parameter int KEYWORD_CHARS = 8,
  parameter int OFFSET_BITS   = 32,
  parameter int LENGTH_BITS   = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire item_t item_i,
  input  wire logic  item_valid_i,
  output logic       item_take_o,
  input  wire logic  room_i,
  output tok_pair_t  wr_o
);

  localparam int IW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;
  localparam int OW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
  localparam int LX = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  phase_e                 state_q, state_d;
  logic [7:0]             word_q [KEYWORD_CHARS];
  logic [7:0]             word_d [KEYWORD_CHARS];
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [OFFSET_BITS-1:0] pend_q, pend_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;

  logic        take, halted, disp, line_start;
  logic        pre_v, disp_v;
  token_t      pre_tok, disp_tok, flush_tok;
  logic [63:0] word_lo;
  logic        kw_hit;
  logic [3:0]  kw_kind;
  logic [LX-1:0] len_x;
  logic [15:0] len_sat;
  cls_e        cls;

  function automatic token_t mk_tok(logic [3:0] kind, logic [OFFSET_BITS-1:0] start,
                                    logic [15:0] len);
    token_t t;
    logic [OW-1:0] sx;
    sx      = OW'(start);
    t.kind  = kind;
    t.start = sx[31:0];
    t.len   = len;
    t.last  = 1'b0;
    return t;
  endfunction

  assign cls         = item_i.cls;
  assign take        = item_valid_i && room_i;
  assign item_take_o = take;
  assign halted      = (state_q == PH_DONE) || (state_q == PH_ERROR);

  // Bytes past the stored prefix are zero, so a length match plus a match
  // of the first eight bytes identifies a keyword.
  always_comb begin
    for (int i = 0; i < KW_BYTES; i++) begin
      word_lo[8*i +: 8] = word_q[i];
    end
    kw_hit  = 1'b0;
    kw_kind = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!kw_hit && len_q == LENGTH_BITS'(KW_LEN[k]) && word_lo == KW_TEXT[k]) begin
        kw_hit  = 1'b1;
        kw_kind = 4'(k);
      end
    end
  end

  assign len_x   = LX'(len_q);
  assign len_sat = (len_x > LX'(16'hFFFF)) ? 16'hFFFF : len_x[15:0];
  assign flush_tok = kw_hit ? mk_tok(kw_kind, pend_q, 16'd0)
                            : mk_tok(TK_IDENT, pend_q, len_sat);

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    pos_d      = pos_q;
    word_d     = word_q;
    len_d      = len_q;
    pre_v      = 1'b0;
    pre_tok    = '0;
    disp_v     = 1'b0;
    disp_tok   = '0;
    disp       = 1'b0;
    line_start = 1'b0;

    if (take && !halted) begin
      if (cls != CL_EOF) begin
        pos_d = pos_q + 1'b1;
      end
      unique case (state_q)
        PH_LINE: begin
          disp       = 1'b1;
          line_start = 1'b1;
        end
        PH_MID: begin
          disp = 1'b1;
        end
        PH_WORD: begin
          if (cls == CL_IDENT) begin
            if (len_q < LENGTH_BITS'(KEYWORD_CHARS)) begin
              word_d[len_q[IW-1:0]] = item_i.data;
            end
            if (len_q != '1) begin
              len_d = len_q + 1'b1;
            end
          end else begin
            pre_v   = 1'b1;
            pre_tok = flush_tok;
            disp    = 1'b1;
          end
        end
        PH_PIPE: begin
          pre_v = 1'b1;
          if (cls == CL_PIPE) begin
            pre_tok = mk_tok(TK_PIPE2, pend_q, 16'd0);
            state_d = PH_MID;
          end else begin
            pre_tok = mk_tok(TK_PIPE, pend_q, 16'd0);
            disp    = 1'b1;
          end
        end
        PH_SPACES: begin
          case (cls)
            CL_SPACE: ;
            CL_LF: begin
              pre_v   = 1'b1;
              pre_tok = mk_tok(TK_NEWLINE, pos_q, 16'd0);
              state_d = PH_LINE;
            end
            CL_HASH: state_d = PH_COMMENT;
            default: begin
              pre_v   = 1'b1;
              pre_tok = mk_tok(TK_INDENT, pend_q, 16'd0);
              disp    = 1'b1;
            end
          endcase
        end
        PH_CR: begin
          pre_v = 1'b1;
          if (cls == CL_LF) begin
            pre_tok = mk_tok(TK_NEWLINE, pend_q, 16'd0);
            state_d = PH_LINE;
          end else begin
            pre_tok = mk_tok(TK_BADCR, pos_q, 16'd0);
            state_d = PH_ERROR;
          end
        end
        PH_COMMENT: begin
          case (cls)
            CL_EOF: begin
              pre_v   = 1'b1;
              pre_tok = mk_tok(TK_EOF, pos_q, 16'd0);
              state_d = PH_DONE;
            end
            CL_CR:   state_d = PH_COMMENT_CR;
            CL_LF:   state_d = PH_LINE;
            default: ;
          endcase
        end
        PH_COMMENT_CR: begin
          if (cls == CL_LF) begin
            state_d = PH_LINE;
          end else begin
            pre_v   = 1'b1;
            pre_tok = mk_tok(TK_BADCR, pos_q, 16'd0);
            state_d = PH_ERROR;
          end
        end
        default: ;
      endcase
    end

    // Handling of a byte as the start of something new.
    if (disp) begin
      unique case (cls)
        CL_EOF: begin
          disp_v   = 1'b1;
          disp_tok = mk_tok(TK_EOF, pos_q, 16'd0);
          state_d  = PH_DONE;
        end
        CL_HASH: state_d = PH_COMMENT;
        CL_PIPE: begin
          state_d = PH_PIPE;
          pend_d  = pos_q;
        end
        CL_CR: begin
          state_d = PH_CR;
          pend_d  = pos_q;
        end
        CL_LF: begin
          disp_v   = 1'b1;
          disp_tok = mk_tok(TK_NEWLINE, pos_q, 16'd0);
          state_d  = PH_LINE;
        end
        CL_EQUALS: begin
          disp_v   = 1'b1;
          disp_tok = mk_tok(TK_EQUALS, pos_q, 16'd0);
          state_d  = PH_MID;
        end
        CL_COLON: begin
          disp_v   = 1'b1;
          disp_tok = mk_tok(TK_COLON, pos_q, 16'd0);
          state_d  = PH_MID;
        end
        CL_SPACE: begin
          if (line_start) begin
            state_d = PH_SPACES;
            pend_d  = pos_q;
          end else begin
            state_d = PH_MID;
          end
        end
        CL_IDENT: begin
          for (int i = 0; i < KEYWORD_CHARS; i++) begin
            word_d[i] = 8'h00;
          end
          word_d[0] = item_i.data;
          len_d     = LENGTH_BITS'(1);
          pend_d    = pos_q;
          state_d   = PH_WORD;
        end
        default: begin
          disp_v   = 1'b1;
          disp_tok = mk_tok(TK_BADCHAR, pos_q, 16'd0);
          state_d  = PH_ERROR;
        end
      endcase
    end

    // Pack the tokens into the write slots and flag the final one.
    wr_o.cnt = 2'(pre_v) + 2'(disp_v);
    wr_o.t0  = pre_v ? pre_tok : disp_tok;
    wr_o.t1  = disp_tok;
    if (pre_v && disp_v) begin
      wr_o.t1.last = 1'b1;
    end else begin
      wr_o.t0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_LINE;
      len_q   <= '0;
      pend_q  <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        word_q[i] <= 8'h00;
      end
    end else begin
      word_q <= word_d;
    end
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == PH_DONE |=> state_q == PH_DONE)
    else $error("scanner left the end-of-file state");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !halted && cls != CL_EOF |=> pos_q == OFFSET_BITS'($past(pos_q) + 1'b1))
    else $error("byte offset did not advance on a taken byte");

  a_no_emit_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted |=> pos_q == $past(pos_q))
    else $error("byte offset moved after the scanner stopped");

endmodule

`default_nettype wire

// ===== hw/rtl/bft_outq.sv =====
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Takes up to two tokens a cycle from the scanner and hands out one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_outq
  import bft_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tok_pair_t wr_i,
  output logic           room_o,
  input  wire logic      pop,
  output logic           empty,
  output token_t         head_o
);

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  token_t        mem_q [OQ_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] count_q;
  logic          rd;

  assign empty  = (count_q == '0);
  assign rd     = pop && !empty;
  assign head_o = mem_q[rp_q];
  // Room is judged without the pop of this cycle, so two slots always fit.
  assign room_o = (count_q <= CW'(OQ_DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_q + PW'(wr_i.cnt);
      count_q <= count_q + CW'(wr_i.cnt) - CW'(rd);
      if (rd) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cnt != 2'd0) begin
      mem_q[wp_q] <= wr_i.t0;
    end
    if (wr_i.cnt == 2'd2) begin
      mem_q[PW'(wp_q + 1'b1)] <= wr_i.t1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.cnt != 2'd0 |-> count_q <= CW'(OQ_DEPTH - 2))
    else $error("token written without room in the result queue");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(OQ_DEPTH))
    else $error("result queue fill count above its depth");

endmodule

`default_nettype wire

// ===== hw/rtl/build_file_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// Build-file tokenizer core
// Byte-stream tokenizer for build descriptions with keyword recognition.
// ----------------------------------------------------------------------------
// Flow: an accepted byte is written into the input queue; the scanner then
// takes it and, while the result queue has room, writes its tokens into the
// result queue, whose head drives the result ports. A word, pipe, CR or
// indent is only closed by the byte that follows it.
// Throughput: one byte per cycle; the scanner stalls only while the result
// queue has fewer than two free slots, and results leave at one per cycle.
// Reset: asynchronous, active low; queues empty, scanner at line start, byte
// offset zero. No clearing pass is needed.
`default_nettype none

module build_file_tokenizer_core
  import bft_pkg::*;
#(
  parameter int KEYWORD_CHARS = 8,
  parameter int OFFSET_BITS   = 32,
  parameter int LENGTH_BITS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        end_of_input_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       token_kind_o,
  output logic [31:0]      token_start_o,
  output logic [15:0]      token_length_o,
  output logic             last_of_run_o
);

  item_t     item;
  logic      item_valid, item_take, room;
  tok_pair_t wr;
  token_t    head;

  bft_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .byte_value_i   (byte_value_i),
    .end_of_input_i (end_of_input_i),
    .item_o         (item),
    .item_valid_o   (item_valid),
    .item_take_i    (item_take)
  );

  bft_back #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .OFFSET_BITS   (OFFSET_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .room_i       (room),
    .wr_o         (wr)
  );

  bft_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .room_o (room),
    .pop    (pop),
    .empty  (empty),
    .head_o (head)
  );

  assign token_kind_o   = head.kind;
  assign token_start_o  = head.start;
  assign token_length_o = head.len;
  assign last_of_run_o  = head.last;

endmodule

`default_nettype wire
